// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, micro-operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int unsigned MAX_BLOCKS_DEF = 64;
	localparam int unsigned PAGE_BYTES_DEF = 4096;
	localparam logic [31:0] HEAP_BASE_RST  = 32'h4000_0000;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	localparam logic [4:0] UOP_NONE     = 5'd0;
	localparam logic [4:0] UOP_ACCEPT   = 5'd1;
	localparam logic [4:0] UOP_RD_IDX   = 5'd2;
	localparam logic [4:0] UOP_IDX_INC  = 5'd3;
	localparam logic [4:0] UOP_FOUND    = 5'd4;
	localparam logic [4:0] UOP_NOTFOUND = 5'd5;
	localparam logic [4:0] UOP_AS_INIT  = 5'd6;
	localparam logic [4:0] UOP_AS_HIT   = 5'd7;
	localparam logic [4:0] UOP_AS_MISS  = 5'd8;
	localparam logic [4:0] UOP_AS_END   = 5'd9;
	localparam logic [4:0] UOP_GROW     = 5'd10;
	localparam logic [4:0] UOP_RESTORE  = 5'd11;
	localparam logic [4:0] UOP_INS_INIT = 5'd12;
	localparam logic [4:0] UOP_INS_RD   = 5'd13;
	localparam logic [4:0] UOP_INS_WR   = 5'd14;
	localparam logic [4:0] UOP_INS_PUT  = 5'd15;
	localparam logic [4:0] UOP_RM_INIT  = 5'd16;
	localparam logic [4:0] UOP_RM_RD    = 5'd17;
	localparam logic [4:0] UOP_RM_WR    = 5'd18;
	localparam logic [4:0] UOP_RM_END   = 5'd19;
	localparam logic [4:0] UOP_RS_LIM   = 5'd20;
	localparam logic [4:0] UOP_RS_PUT   = 5'd21;
	localparam logic [4:0] UOP_CL_EMPTY = 5'd22;
	localparam logic [4:0] UOP_CL_RD    = 5'd23;
	localparam logic [4:0] UOP_CL_TOP   = 5'd24;
	localparam logic [4:0] UOP_CL_CALC  = 5'd25;
	localparam logic [4:0] UOP_DONE     = 5'd26;

	typedef struct packed {
		logic [4:0] uop;
		logic       moved;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       idx_end;
		logic       base_hit;
		logic       as_fit;
		logic       full;
		logic       alloc_ovf;
		logic       rs_last;
		logic       rs_ovf;
		logic       nx_fits;
		logic       ins_at_pos;
		logic       rm_end;
		logic       count_zero;
		logic       out_free;
	} sts_t;

endpackage

// ===== rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator controller
// Sequences table scans, shifts and heap updates as datapath micro-operations.
// ----------------------------------------------------------------------------
module ffha_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ffha_pkg::sts_t sts,
	output ffha_pkg::cmd_t cmd
);
	import ffha_pkg::*;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DISP     = 5'd1;
	localparam logic [4:0] S_FD_RD    = 5'd2;
	localparam logic [4:0] S_FD_EV    = 5'd3;
	localparam logic [4:0] S_RS_LIM   = 5'd4;
	localparam logic [4:0] S_RS_GROW  = 5'd5;
	localparam logic [4:0] S_RS_PUT   = 5'd6;
	localparam logic [4:0] S_AS_INIT  = 5'd7;
	localparam logic [4:0] S_AS_RD    = 5'd8;
	localparam logic [4:0] S_AS_EV    = 5'd9;
	localparam logic [4:0] S_AS_END   = 5'd10;
	localparam logic [4:0] S_GROW     = 5'd11;
	localparam logic [4:0] S_RESTORE  = 5'd12;
	localparam logic [4:0] S_INS_INIT = 5'd13;
	localparam logic [4:0] S_INS_RD   = 5'd14;
	localparam logic [4:0] S_INS_WR   = 5'd15;
	localparam logic [4:0] S_RM_INIT  = 5'd16;
	localparam logic [4:0] S_RM_RD    = 5'd17;
	localparam logic [4:0] S_RM_WR    = 5'd18;
	localparam logic [4:0] S_CL_RD    = 5'd19;
	localparam logic [4:0] S_CL_EV    = 5'd20;
	localparam logic [4:0] S_CL_CALC  = 5'd21;
	localparam logic [4:0] S_DONE     = 5'd22;

	logic [4:0] state_q, state_d;
	logic       mv_q, mv_d;
	logic [4:0] uop;

	always_comb begin
		state_d = state_q;
		mv_d    = mv_q;
		uop     = UOP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					uop     = UOP_ACCEPT;
					mv_d    = 1'b0;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.op == OP_ALLOC) begin
					state_d = S_AS_INIT;
				end else if (sts.op == OP_FREE || sts.op == OP_RESIZE) begin
					state_d = S_FD_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FD_RD: begin
				if (sts.idx_end) begin
					if (sts.op == OP_FREE) begin
						uop     = UOP_NOTFOUND;
						state_d = S_CL_RD;
					end else begin
						state_d = S_AS_INIT;
					end
				end else begin
					uop     = UOP_RD_IDX;
					state_d = S_FD_EV;
				end
			end
			S_FD_EV: begin
				if (sts.base_hit) begin
					uop     = UOP_FOUND;
					state_d = (sts.op == OP_FREE) ? S_RM_INIT : S_RS_LIM;
				end else begin
					uop     = UOP_IDX_INC;
					state_d = S_FD_RD;
				end
			end
			S_RS_LIM: begin
				uop = UOP_RS_LIM;
				if (sts.rs_last) begin
					state_d = sts.rs_ovf ? S_DONE : S_RS_GROW;
				end else if (sts.nx_fits) begin
					state_d = S_RS_PUT;
				end else begin
					mv_d    = 1'b1;
					state_d = S_RM_INIT;
				end
			end
			S_RS_GROW: begin
				uop     = UOP_GROW;
				state_d = S_RS_PUT;
			end
			S_RS_PUT: begin
				uop     = UOP_RS_PUT;
				state_d = S_DONE;
			end
			S_AS_INIT: begin
				uop     = UOP_AS_INIT;
				state_d = S_AS_RD;
			end
			S_AS_RD: begin
				if (sts.idx_end) begin
					state_d = S_AS_END;
				end else begin
					uop     = UOP_RD_IDX;
					state_d = S_AS_EV;
				end
			end
			S_AS_EV: begin
				if (sts.as_fit) begin
					uop     = UOP_AS_HIT;
					state_d = S_AS_END;
				end else begin
					uop     = UOP_AS_MISS;
					state_d = S_AS_RD;
				end
			end
			S_AS_END: begin
				uop = UOP_AS_END;
				if (sts.full || sts.alloc_ovf) begin
					state_d = mv_q ? S_RESTORE : S_DONE;
				end else begin
					state_d = S_GROW;
				end
			end
			S_GROW: begin
				uop     = UOP_GROW;
				state_d = S_INS_INIT;
			end
			S_RESTORE: begin
				uop     = UOP_RESTORE;
				state_d = S_INS_INIT;
			end
			S_INS_INIT: begin
				uop     = UOP_INS_INIT;
				state_d = S_INS_RD;
			end
			S_INS_RD: begin
				if (sts.ins_at_pos) begin
					uop     = UOP_INS_PUT;
					state_d = S_DONE;
				end else begin
					uop     = UOP_INS_RD;
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				uop     = UOP_INS_WR;
				state_d = S_INS_RD;
			end
			S_RM_INIT: begin
				uop     = UOP_RM_INIT;
				state_d = S_RM_RD;
			end
			S_RM_RD: begin
				if (sts.rm_end) begin
					uop     = UOP_RM_END;
					state_d = mv_q ? S_AS_INIT : S_CL_RD;
				end else begin
					uop     = UOP_RM_RD;
					state_d = S_RM_WR;
				end
			end
			S_RM_WR: begin
				uop     = UOP_RM_WR;
				state_d = S_RM_RD;
			end
			S_CL_RD: begin
				if (sts.count_zero) begin
					uop     = UOP_CL_EMPTY;
					state_d = S_CL_CALC;
				end else begin
					uop     = UOP_CL_RD;
					state_d = S_CL_EV;
				end
			end
			S_CL_EV: begin
				uop     = UOP_CL_TOP;
				state_d = S_CL_CALC;
			end
			S_CL_CALC: begin
				uop     = UOP_CL_CALC;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					uop     = UOP_DONE;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cmd.uop   = uop;
	assign cmd.moved = mv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			mv_q    <= mv_d;
		end
	end

endmodule

// ===== rtl/ffha_dp.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator datapath
// Block table memory, heap registers, scan registers and the result register.
// ----------------------------------------------------------------------------
module ffha_dp #(
	parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
	parameter int unsigned PAGE_BYTES = ffha_pkg::PAGE_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ffha_pkg::cmd_t cmd,
	output ffha_pkg::sts_t sts,
	input  logic           cfg_wr_en,
	input  logic [31:0]    cfg_wr_data,
	input  logic [1:0]     opcode,
	input  logic [31:0]    request_size,
	input  logic [31:0]    block_address,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    result_address,
	output logic [1:0]     status,
	output logic           moved,
	output logic [20:0]    pages_added,
	output logic [20:0]    pages_released
);
	import ffha_pkg::*;

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned LG = $clog2(PAGE_BYTES);
	localparam logic [32:0] PAGE_M1 = 33'(PAGE_BYTES - 1);

	logic [63:0] mem_q [MAX_BLOCKS];
	logic [63:0] rd_q;

	logic [31:0]   heap_base_q;
	logic [32:0]   heap_top_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;

	logic [CW-1:0] idx_q, pos_q, u_q;
	logic [31:0]   last_q, lim_q, size_q, addr_in_q, b_q, oldl_q, ins_b_q;
	logic [1:0]    op_q;
	logic [31:0]   addr_q;
	logic [1:0]    status_q;
	logic          moved_q;
	logic [20:0]   added_q, released_q;
	logic [31:0]   res_addr_q;
	logic [1:0]    res_status_q;
	logic          res_moved_q;
	logic [20:0]   res_added_q, res_released_q;

	logic [31:0]   rd_base, rd_lim;
	logic [CW-1:0] idx_inc, idx_dec, cnt_dec, u_inc;
	logic [32:0]   alloc_sum, rs_sum;
	logic [32:0]   lim33, excess, grow_pg, grow_bytes;
	logic [32:0]   span_need, need_pg, have_pg, diff_pg, need_bytes;
	logic          grow_need;
	logic          rd_en, wr_en;
	logic [CW-1:0] rd_addr, wr_addr;
	logic [63:0]   wr_data;

	assign rd_base = rd_q[63:32];
	assign rd_lim  = rd_q[31:0];
	assign idx_inc = idx_q + CW'(1);
	assign idx_dec = idx_q - CW'(1);
	assign cnt_dec = count_q - CW'(1);
	assign u_inc   = u_q + CW'(1);

	assign alloc_sum = {1'b0, last_q} + {1'b0, size_q};
	assign rs_sum    = {1'b0, b_q} + {1'b0, size_q};

	assign lim33      = {1'b0, lim_q};
	assign grow_need  = lim33 > heap_top_q;
	assign excess     = lim33 - heap_top_q;
	assign grow_pg    = (excess + PAGE_M1) >> LG;
	assign grow_bytes = grow_pg << LG;

	assign span_need  = {1'b0, last_q} - {1'b0, heap_base_q};
	assign need_pg    = (span_need + PAGE_M1) >> LG;
	assign have_pg    = (heap_top_q - {1'b0, heap_base_q}) >> LG;
	assign diff_pg    = have_pg - need_pg;
	assign need_bytes = need_pg << LG;

	always_comb begin
		sts.op         = op_q;
		sts.idx_end    = idx_q >= count_q;
		sts.base_hit   = rd_base == addr_in_q;
		sts.as_fit     = (rd_base >= last_q) && ((rd_base - last_q) >= size_q);
		sts.full       = count_q >= CW'(MAX_BLOCKS);
		sts.alloc_ovf  = alloc_sum[32];
		sts.rs_last    = u_inc >= count_q;
		sts.rs_ovf     = rs_sum[32];
		sts.nx_fits    = (rd_base - b_q) >= size_q;
		sts.ins_at_pos = idx_q == pos_q;
		sts.rm_end     = idx_inc >= count_q;
		sts.count_zero = count_q == '0;
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_q;
		case (cmd.uop)
			UOP_RD_IDX: begin
				rd_en = 1'b1;
			end
			UOP_FOUND, UOP_RM_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_inc;
			end
			UOP_INS_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_dec;
			end
			UOP_CL_RD: begin
				rd_en   = 1'b1;
				rd_addr = cnt_dec;
			end
			UOP_INS_WR, UOP_RM_WR: begin
				wr_en = 1'b1;
			end
			UOP_INS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = {ins_b_q, lim_q};
			end
			UOP_RS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = u_q;
				wr_data = {b_q, lim_q};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[IW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= HEAP_BASE_RST;
			heap_top_q  <= {1'b0, HEAP_BASE_RST};
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				heap_base_q <= cfg_wr_data;
				heap_top_q  <= {1'b0, cfg_wr_data};
				count_q     <= '0;
			end else begin
				case (cmd.uop)
					UOP_GROW: begin
						if (grow_need) begin
							heap_top_q <= heap_top_q + grow_bytes;
						end
					end
					UOP_INS_PUT: begin
						count_q <= count_q + CW'(1);
					end
					UOP_RM_END: begin
						count_q <= cnt_dec;
					end
					UOP_CL_CALC: begin
						if (need_pg < have_pg) begin
							heap_top_q <= {1'b0, heap_base_q} + need_bytes;
						end
					end
					default: begin
						heap_top_q <= heap_top_q;
					end
				endcase
			end
			if (cmd.uop == UOP_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.uop)
			UOP_ACCEPT: begin
				op_q       <= opcode;
				size_q     <= (request_size == '0) ? 32'd1 : request_size;
				addr_in_q  <= block_address;
				idx_q      <= '0;
				addr_q     <= '0;
				status_q   <= ST_OK;
				moved_q    <= 1'b0;
				added_q    <= '0;
				released_q <= '0;
			end
			UOP_IDX_INC: begin
				idx_q <= idx_inc;
			end
			UOP_FOUND: begin
				u_q    <= idx_q;
				b_q    <= rd_base;
				oldl_q <= rd_lim;
			end
			UOP_NOTFOUND: begin
				status_q <= ST_NOT_FOUND;
			end
			UOP_AS_INIT: begin
				last_q <= heap_base_q;
				pos_q  <= count_q;
				idx_q  <= '0;
			end
			UOP_AS_HIT: begin
				pos_q <= idx_q;
			end
			UOP_AS_MISS: begin
				last_q <= rd_lim;
				idx_q  <= idx_inc;
			end
			UOP_AS_END: begin
				lim_q   <= alloc_sum[31:0];
				ins_b_q <= last_q;
				addr_q  <= last_q;
				if (sts.full) begin
					status_q <= ST_FULL;
				end else if (alloc_sum[32]) begin
					status_q <= ST_EXHAUSTED;
				end else begin
					status_q <= ST_OK;
				end
			end
			UOP_GROW: begin
				if (grow_need) begin
					added_q <= grow_pg[20:0];
				end
			end
			UOP_RESTORE: begin
				pos_q   <= u_q;
				ins_b_q <= b_q;
				lim_q   <= oldl_q;
			end
			UOP_INS_INIT: begin
				idx_q <= count_q;
			end
			UOP_INS_WR: begin
				idx_q <= idx_dec;
			end
			UOP_INS_PUT: begin
				moved_q <= cmd.moved && (status_q == ST_OK);
			end
			UOP_RM_INIT: begin
				idx_q <= u_q;
			end
			UOP_RM_WR: begin
				idx_q <= idx_inc;
			end
			UOP_RS_LIM: begin
				lim_q    <= rs_sum[31:0];
				addr_q   <= b_q;
				status_q <= rs_sum[32] ? ST_EXHAUSTED : ST_OK;
			end
			UOP_CL_EMPTY: begin
				last_q <= heap_base_q;
			end
			UOP_CL_TOP: begin
				last_q <= rd_lim;
			end
			UOP_CL_CALC: begin
				if (need_pg < have_pg) begin
					released_q <= diff_pg[20:0];
				end
			end
			UOP_DONE: begin
				res_addr_q     <= (status_q == ST_OK) ? addr_q : '0;
				res_status_q   <= status_q;
				res_moved_q    <= moved_q;
				res_added_q    <= added_q;
				res_released_q <= released_q;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign result_address = res_addr_q;
	assign status         = res_status_q;
	assign moved          = res_moved_q;
	assign pages_added    = res_added_q;
	assign pages_released = res_released_q;

endmodule

// ===== rtl/first_fit_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator core
// Allocates, frees and resizes blocks in a page-granular heap region.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (opcode, request_size, block_address) and
// each produces one word on the out channel. The heap base is written through
// cfg_wr_en/cfg_wr_data while the block is idle; the user must keep to this,
// as the block does not enforce it. A write empties the table. One request is
// worked on at a time. Table scans and shifts use the single-port block table
// memory, and a resize that moves its block makes find, remove, scan and
// insert passes. The result sits in an output register, so a new request is
// accepted while a previous result waits; a stalled receiver holds the next
// result back only at the end of its request. Reset empties the table, sets
// the heap base and heap top to their reset value and clears the output valid.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core #(
	parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
	parameter int unsigned PAGE_BYTES = ffha_pkg::PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [31:0] request_size,
	input  logic [31:0] block_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_address,
	output logic [1:0]  status,
	output logic        moved,
	output logic [20:0] pages_added,
	output logic [20:0] pages_released
);
	import ffha_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffha_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.opcode         (opcode),
		.request_size   (request_size),
		.block_address  (block_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_address (result_address),
		.status         (status),
		.moved          (moved),
		.pages_added    (pages_added),
		.pages_released (pages_released)
	);

`ifndef ASSERT_OFF
	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.uop == UOP_INS_PUT) |-> !sts.full)
		else $error("insert into a full block table");

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.uop == UOP_DONE) |=> out_valid)
		else $error("finished request did not raise out_valid");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word accepted while a request is in progress");
`endif

endmodule

// ===== sim/first_fit_heap_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator core testbench
// Drives allocate, free, resize and unused-opcode requests with random gaps on both sides,
// predicts every result word and compares it as a whole word.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	localparam int NBLK = 64;
	localparam longint PG = 4096;
	localparam longint AMAX = 64'hFFFF_FFFF;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] size;
		logic [31:0] addr;
	} req_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [1:0]  st;
		logic        mv;
		logic [20:0] added;
		logic [20:0] released;
	} rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = '0;
	logic [31:0] request_size = '0;
	logic [31:0] block_address = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] result_address;
	logic [1:0]  status;
	logic        moved;
	logic [20:0] pages_added;
	logic [20:0] pages_released;

	first_fit_heap_allocator_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.request_size(request_size), .block_address(block_address),
		.out_valid(out_valid), .out_ready(out_ready), .result_address(result_address),
		.status(status), .moved(moved), .pages_added(pages_added),
		.pages_released(pages_released)
	);

	// Predicted allocator state.
	logic [31:0] p_base;
	logic [31:0] p_bt [NBLK];
	logic [31:0] p_lt [NBLK];
	int          p_cnt;
	longint      p_top;

	req_t   pending_reqs[$];
	rsp_t   expected_rsps[$];
	int     errors = 0;
	int     accepted = 0;
	int     hold_cycles = 0;
	bit     in_taken = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int find_blk(logic [31:0] a);
		for (int i = 0; i < p_cnt; i++)
			if (p_bt[i] == a)
				return i;
		return -1;
	endfunction

	function automatic void ins_blk(int pos, logic [31:0] b, logic [31:0] l);
		if (p_cnt >= NBLK || pos > p_cnt)
			return;
		for (int i = p_cnt; i > pos; i--) begin
			p_bt[i] = p_bt[i-1];
			p_lt[i] = p_lt[i-1];
		end
		p_bt[pos] = b;
		p_lt[pos] = l;
		p_cnt++;
	endfunction

	function automatic void rm_blk(int pos);
		if (pos >= p_cnt)
			return;
		for (int i = pos; i + 1 < p_cnt; i++) begin
			p_bt[i] = p_bt[i+1];
			p_lt[i] = p_lt[i+1];
		end
		p_cnt--;
	endfunction

	function automatic longint grow_heap(longint lim);
		longint pages;
		if (lim <= p_top)
			return 0;
		pages = (lim - p_top + PG - 1) / PG;
		p_top += pages * PG;
		return pages;
	endfunction

	function automatic longint shrink_heap();
		longint top, need, have;
		top = p_base;
		for (int i = 0; i < p_cnt; i++)
			if (longint'(p_lt[i]) > top)
				top = p_lt[i];
		need = (top - longint'(p_base) + PG - 1) / PG;
		have = (p_top - longint'(p_base)) / PG;
		if (need >= have)
			return 0;
		p_top = longint'(p_base) + need * PG;
		return have - need;
	endfunction

	function automatic logic [1:0] first_fit(longint sz, output logic [31:0] a,
			output longint added);
		longint last, b;
		int pos;
		last = p_base;
		pos = p_cnt;
		a = '0;
		added = 0;
		for (int i = 0; i < p_cnt; i++) begin
			b = p_bt[i];
			if (b >= last && b - last >= sz) begin
				pos = i;
				break;
			end
			last = p_lt[i];
		end
		if (p_cnt >= NBLK)
			return ST_FULL;
		if (last + sz > AMAX)
			return ST_EXHAUSTED;
		added = grow_heap(last + sz);
		ins_blk(pos, last[31:0], 32'(last + sz));
		a = last[31:0];
		return ST_OK;
	endfunction

	function automatic rsp_t predict_rsp(req_t r);
		rsp_t o;
		longint sz, added, released, b, lim;
		logic [31:0] a, old_l;
		logic [1:0] st;
		int idx;
		a = '0; st = ST_OK; added = 0; released = 0;
		o = '0;
		sz = r.size;
		if (sz == 0)
			sz = 1;
		if (r.op == OP_ALLOC) begin
			st = first_fit(sz, a, added);
		end else if (r.op == OP_FREE) begin
			idx = find_blk(r.addr);
			if (idx < 0)
				st = ST_NOT_FOUND;
			else
				rm_blk(idx);
			released = shrink_heap();
		end else if (r.op == OP_RESIZE) begin
			idx = find_blk(r.addr);
			if (idx < 0) begin
				st = first_fit(sz, a, added);
			end else begin
				b = p_bt[idx];
				lim = b + sz;
				if (idx + 1 >= p_cnt) begin
					if (lim > AMAX) begin
						st = ST_EXHAUSTED;
					end else begin
						added = grow_heap(lim);
						p_lt[idx] = lim[31:0];
						a = b[31:0];
					end
				end else if (longint'(p_bt[idx+1]) - b >= sz) begin
					p_lt[idx] = lim[31:0];
					a = b[31:0];
				end else begin
					old_l = p_lt[idx];
					rm_blk(idx);
					st = first_fit(sz, a, added);
					if (st == ST_OK) begin
						o.mv = 1'b1;
					end else begin
						ins_blk(idx, b[31:0], old_l);
						a = '0;
					end
				end
			end
		end
		if (st != ST_OK)
			a = '0;
		o.addr = a;
		o.st = st;
		o.added = added[20:0];
		o.released = released[20:0];
		return o;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(9) < 4)
			return 0;
		if ($urandom_range(19) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3);
	endfunction

	// Input acceptance: predicts in the block's order.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_rsps.push_back(predict_rsp({opcode, request_size, block_address}));
			accepted++;
			in_taken = 1'b1;
		end
	end

	// Driver.
	int in_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req_t r;
					r = pending_reqs.pop_front();
					opcode <= r.op;
					request_size <= r.size;
					block_address <= r.addr;
					in_valid <= 1'b1;
					in_gap = gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	int out_gap = 0;
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap--;
		end else begin
			out_ready <= 1'b1;
			out_gap = gap_len();
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			rsp_t e, g;
			g = {result_address, status, moved, pages_added, pages_released};
			if (expected_rsps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word %h", g);
			end else begin
				e = expected_rsps.pop_front();
				if (g !== e) begin
					errors++;
					if (errors <= 10)
						$display({"word mismatch: exp addr %h st %0d mv %0d add %0d",
							" rel %0d, got addr %h st %0d mv %0d add %0d rel %0d"},
							e.addr, e.st, e.mv, e.added, e.released,
							g.addr, g.st, g.mv, g.added, g.released);
				end
			end
		end
	end

	function automatic logic [31:0] pick_addr();
		if (p_cnt > 0 && $urandom_range(9) < 8)
			return p_bt[$urandom_range(p_cnt - 1)];
		if ($urandom_range(1))
			return $urandom;
		return p_base + $urandom_range(300);
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(9))
			0: return 0;
			1: return $urandom;
			2: return $urandom_range(20000, 4000);
			default: return $urandom_range(600);
		endcase
	endfunction

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_base(logic [31:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		p_base = v;
		p_cnt = 0;
		p_top = v;
	endtask

	// Random phase; the predicted block table is also used to pick addresses.
	task automatic random_phase(int n);
		req_t r;
		for (int i = 0; i < n; i++) begin
			r.op = ($urandom_range(19) == 0) ? OP_UNUSED : 2'($urandom_range(2));
			r.size = pick_size();
			r.addr = pick_addr();
			pending_reqs.push_back(r);
			while (pending_reqs.size() > 0 || in_valid)
				@(posedge clk);
		end
		wait_idle();
	endtask

	initial begin
		logic [31:0] bases[4];
		p_base = HEAP_BASE_RST;
		p_cnt = 0;
		p_top = HEAP_BASE_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset base.
		pending_reqs.push_back({OP_ALLOC, 32'd0, 32'd0});
		pending_reqs.push_back({OP_ALLOC, 32'd100, 32'd0});
		pending_reqs.push_back({OP_ALLOC, 32'd5000, 32'd0});
		pending_reqs.push_back({OP_RESIZE, 32'd50, HEAP_BASE_RST});
		pending_reqs.push_back({OP_RESIZE, 32'd9000, HEAP_BASE_RST + 32'd1});
		pending_reqs.push_back({OP_FREE, 32'd0, HEAP_BASE_RST + 32'd1});
		pending_reqs.push_back({OP_FREE, 32'd0, 32'hFFFF_FFFF});
		pending_reqs.push_back({OP_RESIZE, 32'd7, 32'h1234_5678});
		pending_reqs.push_back({OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		pending_reqs.push_back({OP_ALLOC, 32'hFFFF_FFFF, 32'd0});
		pending_reqs.push_back({OP_RESIZE, 32'hFFFF_FFFF, HEAP_BASE_RST});
		pending_reqs.push_back({OP_ALLOC, 32'hBFFF_0000, 32'd0});
		wait_idle();

		// Fill the table past full while the receiver stalls.
		write_base(32'h0000_1000);
		for (int i = 0; i < 70; i++)
			pending_reqs.push_back({OP_ALLOC, 32'($urandom_range(200)), 32'd0});
		hold_cycles = 3000;
		wait (hold_cycles == 0);
		wait_idle();
		random_phase(100);

		bases = '{32'd0, 32'hFFFF_F000, 32'h8000_0000, HEAP_BASE_RST};
		foreach (bases[k]) begin
			write_base(bases[k]);
			pending_reqs.push_back({OP_ALLOC, 32'hFFFF_FFFF, 32'd0});
			pending_reqs.push_back({OP_ALLOC, 32'd10, 32'd0});
			random_phase(k == 1 ? 30 : 120);
		end

		wait_idle();
		if (errors == 0)
			$display("first_fit_heap_allocator_core: match");
		else
			$display("first_fit_heap_allocator_core: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("first_fit_heap_allocator_core: mismatch");
		$finish;
	end

endmodule
